// File: hw/rtl/ocdr_pkg.sv
// ----------------------------------------------------------------------------
// ocdr_pkg
// Shared types and constants of the open-chain diffusion residual block.
// ----------------------------------------------------------------------------
package ocdr_pkg;

  // request function codes
  typedef enum logic [1:0] {
    FUNC_BOND    = 2'd0,
    FUNC_INIT    = 2'd1,
    FUNC_EVOLVE  = 2'd2,
    FUNC_COMPARE = 2'd3
  } func_t;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [1:0] REG_INV_TAU   = 2'd1;
  localparam logic [1:0] REG_STEPS     = 2'd2;

  // reset values of the configuration registers
  localparam logic [23:0] STEP_SIZE_RST = 24'd419430;
  localparam logic [31:0] INV_TAU_RST   = 32'd0;
  localparam logic [9:0]  STEPS_RST     = 10'd40;

  // fraction bits of the time step
  localparam int STEP_FRAC = 24;
  // residual scale shift (Q16.16 result)
  localparam int RES_SHIFT = 16;
  // divider numerator width: 33-bit difference shifted by RES_SHIFT
  localparam int NUM_W = 33 + RES_SHIFT;
  localparam int CNT_W = $clog2(NUM_W + 1);

  typedef struct packed {
    func_t              func;
    logic [5:0]         index;
    logic signed [31:0] value;
    logic signed [31:0] aux_value;
  } in_req_t;

  typedef struct packed {
    logic [5:0]         site;
    logic signed [31:0] residual;
    logic [1:0]         status;
  } out_rsp_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -72'sh80000000) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/open_chain_diffusion_residuals.sv
// ----------------------------------------------------------------------------
// open_chain_diffusion_residuals
// Fixed-point explicit Euler 1-D diffusion chain with residual compare.
// ----------------------------------------------------------------------------
// One request is worked at a time and in_stall stays high until it is done.
// Bond loads write the bond and then its mirror; initial-site loads write one
// site. A compare runs the bit-serial restoring divider (one quotient bit a
// cycle), or skips it when the error is zero. An evolve runs steps_per_compare
// Euler steps: each inner site goes through one shared 34x34 multiplier four
// times (decay, right flux, left flux, time step) plus a memory read and write.
// A finished result sits in the output register, and the next request is
// taken while it waits.
// ----------------------------------------------------------------------------
module open_chain_diffusion_residuals #(
  parameter int NSITES    = 64,
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ocdr_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ocdr_pkg::out_rsp_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int SW = $clog2(NSITES);
  localparam int AW = 71 - FRAC_BITS;

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_BOND2   = 15'h0002,
    S_EV_INIT = 15'h0004,
    S_EV_LOAD = 15'h0008,
    S_EV_RD   = 15'h0010,
    S_EV_DEC  = 15'h0020,
    S_EV_RGT  = 15'h0040,
    S_EV_LFT  = 15'h0080,
    S_EV_RATE = 15'h0100,
    S_EV_INC  = 15'h0200,
    S_EV_WR   = 15'h0400,
    S_CMP_LD  = 15'h0800,
    S_CMP_DIV = 15'h1000,
    S_CMP_FIN = 15'h2000,
    S_CMP_OUT = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [23:0] step_r;
  logic [31:0] itau_r;
  logic [9:0]  spc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ocdr_pkg::STEP_SIZE_RST;
      itau_r <= ocdr_pkg::INV_TAU_RST;
      spc_r  <= ocdr_pkg::STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ocdr_pkg::REG_STEP_SIZE: step_r <= cfg_wdata[23:0];
        ocdr_pkg::REG_INV_TAU:   itau_r <= cfg_wdata;
        ocdr_pkg::REG_STEPS:     spc_r  <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // request decode
  logic in_acc;
  logic idx_site_ok, idx_bond_ok;
  logic [SW-1:0] idx_a;
  logic signed [32:0] avg_sum;

  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign idx_site_ok = int'(in_data.index) < NSITES;
  assign idx_bond_ok = int'(in_data.index) < NSITES - 1;
  assign idx_a       = SW'(in_data.index);
  assign avg_sum     = 33'(in_data.value) + 33'(in_data.aux_value);

  // working registers
  logic [SW-1:0]      t_r, t_nxt;
  logic [9:0]         scnt_r, scnt_nxt;
  logic signed [31:0] prev_r, prev_nxt, cur_r, cur_nxt, nxt_r, nxt_nxt;
  logic signed [31:0] dprev_r, dprev_nxt, dcur_r, dcur_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [31:0] rate_r, rate_nxt;
  logic signed [67:0] prod_r, prod_nxt;
  logic [SW-1:0]      mir_r, mir_nxt;
  logic [31:0]        bval_r, bval_nxt;
  logic [5:0]         site_r, site_nxt;
  logic signed [31:0] meas_r, meas_nxt, err_r, err_nxt;
  logic [ocdr_pkg::NUM_W-1:0] dq_r, dq_nxt;
  logic [32:0]        rem_r, rem_nxt;
  logic [31:0]        dvs_r, dvs_nxt;
  logic [ocdr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic [1:0]         stat_r, stat_nxt;

  // site memory and bond memory
  logic signed [31:0] site_mem [NSITES];
  logic signed [31:0] bond_mem [NSITES-1];
  logic [NSITES-1:0]   site_vld_r;
  logic [NSITES-2:0]   bond_vld_r;
  logic [SW-1:0]       s_raddr, s_waddr, b_raddr, b_waddr;
  logic                s_we, b_we;
  logic signed [31:0]  s_wdata, b_wdata;
  logic signed [31:0]  s_rdata_r, b_rdata_r;
  logic                s_rvld_r, b_rvld_r;
  logic signed [31:0]  s_val, b_val;

  always_ff @(posedge clk) begin
    if (s_we) begin
      site_mem[s_waddr] <= s_wdata;
    end
    s_rdata_r <= site_mem[s_raddr];
    if (b_we) begin
      bond_mem[b_waddr] <= b_wdata;
    end
    b_rdata_r <= bond_mem[b_raddr];
  end

  // valid bits: a never-written entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_vld_r <= '0;
      bond_vld_r <= '0;
      s_rvld_r   <= 1'b0;
      b_rvld_r   <= 1'b0;
    end else begin
      if (s_we) begin
        site_vld_r[s_waddr] <= 1'b1;
      end
      if (b_we) begin
        bond_vld_r[b_waddr] <= 1'b1;
      end
      s_rvld_r <= site_vld_r[s_raddr];
      b_rvld_r <= bond_vld_r[b_raddr];
    end
  end

  assign s_val = s_rvld_r ? s_rdata_r : '0;
  assign b_val = b_rvld_r ? b_rdata_r : '0;

  // shared multiplier operand select
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_sh;
  logic signed [AW-1:0] term;

  always_comb begin
    case (state_r)
      S_EV_DEC: begin
        mul_a = 34'(cur_r);
        mul_b = signed'({2'b00, itau_r});
      end
      S_EV_RGT: begin
        mul_a = 34'(dcur_r);
        mul_b = 34'(nxt_r) - 34'(cur_r);
      end
      S_EV_LFT: begin
        mul_a = 34'(dprev_r);
        mul_b = 34'(cur_r) - 34'(prev_r);
      end
      default: begin
        mul_a = signed'({10'd0, step_r});
        mul_b = 34'(rate_r);
      end
    endcase
  end

  assign prod_sh = prod_r >>> FRAC_BITS;
  assign term    = signed'(prod_sh[AW-1:0]);

  // compare preparation
  logic signed [32:0] cmp_diff;
  logic signed [ocdr_pkg::NUM_W-1:0] cmp_num;
  logic signed [32:0] err_ext;
  logic [32:0] trial;

  assign cmp_diff = 33'(s_val) - 33'(meas_r);
  assign cmp_num  = ocdr_pkg::NUM_W'(cmp_diff) <<< ocdr_pkg::RES_SHIFT;
  assign err_ext  = 33'(err_r);
  assign trial    = {rem_r[31:0], dq_r[ocdr_pkg::NUM_W-1]} - {1'b0, dvs_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    scnt_nxt  = scnt_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    nxt_nxt   = nxt_r;
    dprev_nxt = dprev_r;
    dcur_nxt  = dcur_r;
    acc_nxt   = acc_r;
    rate_nxt  = rate_r;
    prod_nxt  = prod_r;
    mir_nxt   = mir_r;
    bval_nxt  = bval_r;
    site_nxt  = site_r;
    meas_nxt  = meas_r;
    err_nxt   = err_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    s_raddr   = t_r + SW'(1);
    s_we      = 1'b0;
    s_waddr   = t_r;
    s_wdata   = '0;
    b_raddr   = t_r;
    b_we      = 1'b0;
    b_waddr   = idx_a;
    b_wdata   = in_data.value;

    case (state_r)
      S_IDLE: begin
        s_raddr = idx_a;
        if (in_acc) begin
          case (in_data.func)
            ocdr_pkg::FUNC_BOND: begin
              if (idx_bond_ok) begin
                b_we      = 1'b1;
                mir_nxt   = SW'(NSITES - 2) - idx_a;
                bval_nxt  = in_data.value;
                state_nxt = S_BOND2;
              end
            end
            ocdr_pkg::FUNC_INIT: begin
              if (idx_site_ok) begin
                s_we    = 1'b1;
                s_waddr = idx_a;
                if (idx_a != '0 && idx_a != SW'(NSITES - 1)) begin
                  s_wdata = avg_sum[32:1];
                end
              end
            end
            ocdr_pkg::FUNC_EVOLVE: begin
              if (spc_r != '0) begin
                scnt_nxt  = spc_r;
                state_nxt = S_EV_INIT;
              end
            end
            default: begin
              if (idx_site_ok) begin
                site_nxt = in_data.index;
                meas_nxt = in_data.value;
                err_nxt  = in_data.aux_value;
                if (in_data.aux_value == '0) begin
                  res_nxt   = '0;
                  stat_nxt  = ocdr_pkg::STAT_ZERO;
                  state_nxt = S_CMP_OUT;
                end else begin
                  state_nxt = S_CMP_LD;
                end
              end
            end
          endcase
        end
      end
      // mirror bond write
      S_BOND2: begin
        b_we      = 1'b1;
        b_waddr   = mir_r;
        b_wdata   = bval_r;
        state_nxt = S_IDLE;
      end
      // start of one Euler step: fetch first inner site and bond 0
      S_EV_INIT: begin
        s_raddr   = SW'(1);
        b_raddr   = '0;
        state_nxt = S_EV_LOAD;
      end
      S_EV_LOAD: begin
        cur_nxt   = s_val;
        dprev_nxt = b_val;
        prev_nxt  = '0;
        t_nxt     = SW'(1);
        state_nxt = S_EV_RD;
      end
      S_EV_RD: begin
        state_nxt = S_EV_DEC;
      end
      // decay product
      S_EV_DEC: begin
        nxt_nxt   = s_val;
        dcur_nxt  = b_val;
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_EV_RGT;
      end
      // right flux product
      S_EV_RGT: begin
        acc_nxt   = -term;
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_EV_LFT;
      end
      // left flux product
      S_EV_LFT: begin
        acc_nxt   = acc_r + term;
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_EV_RATE;
      end
      S_EV_RATE: begin
        rate_nxt  = ocdr_pkg::sat32(72'(acc_r - term));
        state_nxt = S_EV_INC;
      end
      // time step product
      S_EV_INC: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_EV_WR;
      end
      // update the site and slide the window
      S_EV_WR: begin
        s_we      = 1'b1;
        s_waddr   = t_r;
        s_wdata   = ocdr_pkg::sat32(72'(cur_r) + 72'(prod_r >>> ocdr_pkg::STEP_FRAC));
        prev_nxt  = cur_r;
        cur_nxt   = nxt_r;
        dprev_nxt = dcur_r;
        if (t_r == SW'(NSITES - 2)) begin
          if (scnt_r == 10'd1) begin
            state_nxt = S_IDLE;
          end else begin
            scnt_nxt  = scnt_r - 10'd1;
            state_nxt = S_EV_INIT;
          end
        end else begin
          t_nxt     = t_r + SW'(1);
          state_nxt = S_EV_RD;
        end
      end
      // signed operands to magnitudes for the divider
      S_CMP_LD: begin
        dq_nxt    = cmp_num[ocdr_pkg::NUM_W-1] ? ocdr_pkg::NUM_W'(-cmp_num)
                                               : ocdr_pkg::NUM_W'(cmp_num);
        dvs_nxt   = err_ext[32] ? 32'(-err_ext) : 32'(err_ext);
        neg_nxt   = cmp_num[ocdr_pkg::NUM_W-1] ^ err_r[31];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_CMP_DIV;
      end
      // one restoring division step
      S_CMP_DIV: begin
        if (!trial[32]) begin
          rem_nxt = trial;
        end else begin
          rem_nxt = {rem_r[31:0], dq_r[ocdr_pkg::NUM_W-1]};
        end
        dq_nxt  = {dq_r[ocdr_pkg::NUM_W-2:0], !trial[32]};
        cnt_nxt = cnt_r + ocdr_pkg::CNT_W'(1);
        if (cnt_r == ocdr_pkg::CNT_W'(ocdr_pkg::NUM_W - 1)) begin
          state_nxt = S_CMP_FIN;
        end
      end
      // sign and saturation
      S_CMP_FIN: begin
        stat_nxt = ocdr_pkg::STAT_OK;
        if (neg_r) begin
          if (dq_r > ocdr_pkg::NUM_W'(33'h080000000)) begin
            res_nxt  = -32'sh80000000;
            stat_nxt = ocdr_pkg::STAT_SAT;
          end else begin
            res_nxt = 32'(-dq_r);
          end
        end else begin
          if (dq_r > ocdr_pkg::NUM_W'(33'h07FFFFFFF)) begin
            res_nxt  = 32'sh7FFFFFFF;
            stat_nxt = ocdr_pkg::STAT_SAT;
          end else begin
            res_nxt = signed'(dq_r[31:0]);
          end
        end
        state_nxt = S_CMP_OUT;
      end
      S_CMP_OUT: begin
        if (!out_valid || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    scnt_r  <= scnt_nxt;
    prev_r  <= prev_nxt;
    cur_r   <= cur_nxt;
    nxt_r   <= nxt_nxt;
    dprev_r <= dprev_nxt;
    dcur_r  <= dcur_nxt;
    acc_r   <= acc_nxt;
    rate_r  <= rate_nxt;
    prod_r  <= prod_nxt;
    mir_r   <= mir_nxt;
    bval_r  <= bval_nxt;
    site_r  <= site_nxt;
    meas_r  <= meas_nxt;
    err_r   <= err_nxt;
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    res_r   <= res_nxt;
    stat_r  <= stat_nxt;
  end

  // output register
  logic out_valid_r;
  ocdr_pkg::out_rsp_t out_data_r;
  logic out_load;

  assign out_load = (state_r == S_CMP_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.site     <= site_r;
      out_data_r.residual <= res_r;
      out_data_r.status   <= stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a new result appears only after the output state
  a_out_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_CMP_OUT))
    else $error("result without compare");

  // zero error always gives a zero residual
  a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ocdr_pkg::STAT_ZERO |-> out_data_r.residual == '0)
    else $error("zero-error residual not zero");

  // the site walk stays on inner sites
  a_inner_site: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EV_WR |-> t_r >= SW'(1) && t_r <= SW'(NSITES - 2))
    else $error("evolve wrote an end site");

  // an evolve with work starts a step
  a_ev_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.func == ocdr_pkg::FUNC_EVOLVE && spc_r != '0 |=> state_r == S_EV_INIT)
    else $error("evolve did not start");

endmodule

// File: tb/open_chain_diffusion_residuals_check.sv
// ----------------------------------------------------------------------------
// open_chain_diffusion_residuals_check
// Watches the request, result and register ports of the diffusion block,
// keeps its own copy of the chain, bonds and registers, predicts the residual
// of every accepted compare request and checks results in order.
// ----------------------------------------------------------------------------
module open_chain_diffusion_residuals_check #(
  parameter int NSITES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ocdr_pkg::in_req_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ocdr_pkg::out_rsp_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  // predicted block state
  logic [23:0] step_reg;
  logic [31:0] tau_reg;
  logic [9:0]  steps_reg;
  longint      chain[NSITES];
  longint      coeff[NSITES-1];
  ocdr_pkg::out_rsp_t residual_q[$];

  function automatic longint clamp_word(input longint v, output bit hit);
    hit = 1'b0;
    if (v > WORD_MAX) begin
      hit = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      hit = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  // one explicit euler step over all inner sites, from old values
  task automatic diffuse_once();
    longint nx[NSITES];
    longint x, decay, right_flux, left_flux, rate, inc;
    bit     hit;
    for (int t = 1; t < NSITES - 1; t++) begin
      x          = chain[t];
      decay      = (x * longint'({32'b0, tau_reg})) >>> 24;
      right_flux = (coeff[t] * (chain[t+1] - x)) >>> 24;
      left_flux  = (coeff[t-1] * (x - chain[t-1])) >>> 24;
      rate       = clamp_word(right_flux - left_flux - decay, hit);
      inc        = (longint'({40'b0, step_reg}) * rate) >>> ocdr_pkg::STEP_FRAC;
      nx[t]      = clamp_word(x + inc, hit);
    end
    nx[0] = 0;
    nx[NSITES-1] = 0;
    chain = nx;
  endtask

  // apply one accepted request to the predicted state
  task automatic predict_request(input ocdr_pkg::in_req_t req);
    longint   v, a, num, res;
    bit       hit;
    ocdr_pkg::out_rsp_t rsp;
    v = longint'(req.value);
    a = longint'(req.aux_value);
    case (req.func)
      ocdr_pkg::FUNC_BOND: begin
        if (req.index < NSITES - 1) begin
          coeff[req.index] = v;
          coeff[NSITES-2-req.index] = v;
        end
      end
      ocdr_pkg::FUNC_INIT: begin
        if (req.index < NSITES) begin
          chain[req.index] = (req.index == 0 || req.index == NSITES - 1) ?
                             0 : ((v + a) >>> 1);
        end
      end
      ocdr_pkg::FUNC_EVOLVE: begin
        for (int s = 0; s < steps_reg; s++) diffuse_once();
      end
      default: begin
        if (req.index < NSITES) begin
          rsp.site = req.index;
          if (a == 0) begin
            rsp.residual = '0;
            rsp.status   = ocdr_pkg::STAT_ZERO;
          end else begin
            num = (chain[req.index] - v) * 65536;
            res = clamp_word(num / a, hit);
            rsp.residual = res[31:0];
            rsp.status   = hit ? ocdr_pkg::STAT_SAT : ocdr_pkg::STAT_OK;
          end
          residual_q = {residual_q, rsp};
        end
      end
    endcase
  endtask

  assign pending = residual_q.size();

  always @(posedge clk) begin
    ocdr_pkg::out_rsp_t want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      step_reg  <= ocdr_pkg::STEP_SIZE_RST;
      tau_reg   <= ocdr_pkg::INV_TAU_RST;
      steps_reg <= ocdr_pkg::STEPS_RST;
      foreach (chain[i]) chain[i] = 0;
      foreach (coeff[i]) coeff[i] = 0;
      residual_q.delete();
      errors <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          ocdr_pkg::REG_STEP_SIZE: step_reg  <= cfg_wdata[23:0];
          ocdr_pkg::REG_INV_TAU:   tau_reg   <= cfg_wdata;
          ocdr_pkg::REG_STEPS:     steps_reg <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      // result check against oldest prediction
      if (out_valid && !out_stall) begin
        if (residual_q.size() == 0) begin
          $error("unexpected result site=%0d residual=%0d status=%0d",
                 out_data.site, out_data.residual, out_data.status);
          bad++;
        end else begin
          want = residual_q.pop_front();
          if (out_data.site !== want.site) begin
            $error("site expected %0d actual %0d", want.site, out_data.site);
            bad++;
          end
          if (out_data.residual !== want.residual) begin
            $error("residual expected %0d actual %0d", want.residual,
                   out_data.residual);
            bad++;
          end
          if (out_data.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status,
                   out_data.status);
            bad++;
          end
        end
      end
      errors <= errors + bad;
      // request prediction
      if (in_valid && !in_stall) predict_request(in_data);
    end
  end

endmodule

// File: tb/open_chain_diffusion_residuals_test.sv
// ----------------------------------------------------------------------------
// open_chain_diffusion_residuals_test
// Drives directed and random requests and register settings into the
// diffusion block with random idling on both channels; the checker beside
// the block predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module open_chain_diffusion_residuals_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ocdr_pkg::in_req_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ocdr_pkg::out_rsp_t out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  int          errors;
  int          pending;
  bit          no_idle = 1'b0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  always #10 clk = ~clk;

  open_chain_diffusion_residuals uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  open_chain_diffusion_residuals_check checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
  );

  // result-side stall, a fresh random hold after every result
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (out_valid && !out_stall) begin
      n = no_idle ? 0 : $urandom_range(0, 12);
      hold_cnt  <= n;
      out_stall <= (n != 0);
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= (hold_cnt > 1);
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL open_chain_diffusion_residuals");
      $finish;
    end
  end

  task automatic send_request(input ocdr_pkg::in_req_t req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_request(input ocdr_pkg::func_t f, input int idx, input int val,
                             input int aux);
    ocdr_pkg::in_req_t req;
    req.func      = f;
    req.index     = idx[5:0];
    req.value     = val;
    req.aux_value = aux;
    send_request(req);
  endtask

  // hold the sender until every result is back and the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || in_stall) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // one register write, after which the write port goes quiet
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
  endfunction

  // mostly loads and compares with moderate values, a few evolves, some noise
  function automatic ocdr_pkg::in_req_t random_request();
    ocdr_pkg::in_req_t req;
    int      w;
    w = $urandom_range(0, 99);
    req.index     = 6'($urandom_range(0, 63));
    req.value     = pick_value();
    req.aux_value = pick_value();
    if (w < 15) begin
      req.func = ocdr_pkg::FUNC_BOND;
      if ($urandom_range(0, 3) != 0) req.value = $urandom_range(0, 32'h0100_0000);
    end else if (w < 40) begin
      req.func = ocdr_pkg::FUNC_INIT;
    end else if (w < 47) begin
      req.func = ocdr_pkg::FUNC_EVOLVE;
    end else begin
      req.func = ocdr_pkg::FUNC_COMPARE;
      if ($urandom_range(0, 19) == 0) req.aux_value = '0;
    end
    return req;
  endfunction

  task automatic random_run(input int count, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      send_request(random_request());
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and end cases at reset settings
    put_request(ocdr_pkg::FUNC_BOND, 0, 32'h0100_0000, 0);
    put_request(ocdr_pkg::FUNC_BOND, 62, 32'h0080_0000, 0);
    put_request(ocdr_pkg::FUNC_BOND, 30, 32'h8000_0000, 0);
    put_request(ocdr_pkg::FUNC_BOND, 63, 32'h7FFF_FFFF, 0);
    put_request(ocdr_pkg::FUNC_INIT, 0, 32'h0100_0000, 32'h0100_0000);
    put_request(ocdr_pkg::FUNC_INIT, 63, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put_request(ocdr_pkg::FUNC_INIT, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put_request(ocdr_pkg::FUNC_INIT, 2, 32'h8000_0000, 32'h8000_0000);
    put_request(ocdr_pkg::FUNC_INIT, 10, 32'h0100_0000, 32'hFFFF_FFFF);
    put_request(ocdr_pkg::FUNC_COMPARE, 0, 32'h1234_5678, 0);
    put_request(ocdr_pkg::FUNC_COMPARE, 1, 32'h8000_0000, 1);
    put_request(ocdr_pkg::FUNC_COMPARE, 2, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    put_request(ocdr_pkg::FUNC_COMPARE, 63, 5, 3);
    put_request(ocdr_pkg::FUNC_COMPARE, 10, 0, 32'h8000_0000);
    put_request(ocdr_pkg::FUNC_EVOLVE, 0, 0, 0);
    put_request(ocdr_pkg::FUNC_COMPARE, 10, 32'h0010_0000, 32'h0100_0000);
    put_request(ocdr_pkg::FUNC_COMPARE, 1, 0, 32'h7FFF_FFFF);
    put_request(ocdr_pkg::FUNC_BOND, 30, 32'h0040_0000, 0);
    put_request(ocdr_pkg::FUNC_COMPARE, 31, 32'hFFFF_FFFF, 32'h0000_0100);
    drain();

    // largest step, no decay, single steps
    write_reg(ocdr_pkg::REG_STEP_SIZE, 32'h00FF_FFFF);
    write_reg(ocdr_pkg::REG_INV_TAU, 32'h0);
    write_reg(ocdr_pkg::REG_STEPS, 32'd1);
    random_run(100, -1);

    // zero step, largest decay, back to back
    no_idle = 1'b1;
    write_reg(ocdr_pkg::REG_STEP_SIZE, 32'h0);
    write_reg(ocdr_pkg::REG_INV_TAU, 32'hFFFF_FFFF);
    write_reg(ocdr_pkg::REG_STEPS, 32'd3);
    random_run(80, -1);
    no_idle = 1'b0;

    // one long evolve at the most steps
    write_reg(ocdr_pkg::REG_STEP_SIZE, ocdr_pkg::STEP_SIZE_RST);
    write_reg(ocdr_pkg::REG_INV_TAU, 32'h0000_4000);
    write_reg(ocdr_pkg::REG_STEPS, 32'd1023);
    put_request(ocdr_pkg::FUNC_EVOLVE, 0, 0, 0);
    for (int s = 1; s < 6; s++) begin
      put_request(ocdr_pkg::FUNC_COMPARE, s * 7, 0, 32'h0001_0000);
    end
    drain();

    // random settings, oversized step count wraps to one
    write_reg(ocdr_pkg::REG_STEP_SIZE, $urandom);
    write_reg(ocdr_pkg::REG_INV_TAU, $urandom_range(0, 32'h0200_0000));
    write_reg(ocdr_pkg::REG_STEPS, 32'h0000_0401);
    random_run(100, 50);

    // smallest step, unit decay
    write_reg(ocdr_pkg::REG_STEP_SIZE, 32'd1);
    write_reg(ocdr_pkg::REG_INV_TAU, 32'h0100_0000);
    write_reg(ocdr_pkg::REG_STEPS, 32'd2);
    random_run(100, -1);

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS open_chain_diffusion_residuals");
    end else begin
      $display("FAIL open_chain_diffusion_residuals");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ocdr_pkg.sv
hw/rtl/open_chain_diffusion_residuals.sv
tb/open_chain_diffusion_residuals_check.sv
tb/open_chain_diffusion_residuals_test.sv
